// ===== rtl/core/vca_pkg.sv =====
// Shared types and constants of the voice channel allocator.
// Used by vca_ctrl, vca_dpath and voice_channel_allocator_core; no dependencies.
`default_nettype none

package vca_pkg;

   localparam int CHANNELS         = 8;
   localparam int CNT_W            = 4;
   localparam int MAX_DIST_DEFAULT = 2025;
   localparam int PRIO_STEPS       = 10;
   localparam int DIST_W           = 17;

   localparam logic [2:0] KIND_START    = 3'd0;
   localparam logic [2:0] KIND_DONE     = 3'd1;
   localparam logic [2:0] KIND_STOP     = 3'd2;
   localparam logic [2:0] KIND_STOP_ALL = 3'd3;
   localparam logic [2:0] KIND_RELINK   = 3'd4;
   localparam logic [2:0] KIND_UPDATE   = 3'd5;

   localparam logic [1:0] CSR_ACTIVE_CHANNELS = 2'd0;
   localparam logic [1:0] CSR_MASTER_VOLUME   = 2'd1;
   localparam logic [1:0] CSR_SOUND_ENABLED   = 2'd2;

   localparam logic signed [4:0] LIMIT_NONE = -5'sd1;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_CHECK  = 13'b0000000000010,
      ST_ABS    = 13'b0000000000100,
      ST_SUM    = 13'b0000000001000,
      ST_PRIO   = 13'b0000000010000,
      ST_LIMIT  = 13'b0000000100000,
      ST_SCAN   = 13'b0000001000000,
      ST_STOP   = 13'b0000010000000,
      ST_RELINK = 13'b0000100000000,
      ST_STEAL  = 13'b0001000000000,
      ST_COMMIT = 13'b0010000000000,
      ST_SIMPLE = 13'b0100000000000,
      ST_FINISH = 13'b1000000000000
   } state_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_LOAD, OP_CHECK, OP_ABS, OP_SUM, OP_PRIO, OP_LIMIT,
      OP_SCAN, OP_STOP, OP_RELINK, OP_STEAL, OP_COMMIT, OP_SIMPLE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   load_out;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_kind;
      logic       start_ok;
      logic       upd_ok;
      logic       is_update;
      logic       far;
      logic       limit_skip;
      logic       scan_end;
      logic       lim_fail;
      logic       pick_hit;
      logic       steal_hit;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/voice_channel_allocator_core.sv =====
// Voice channel allocator: one item at a time; the next item waits until the last is done.
// A start request ends at once when gated, and otherwise may run the limit pass, the
// origin/free pass and the steal pass over the n active channels. A stalled result
// holds the item until the output register is free; that register lets the next item
// enter while a result waits.
// Synchronous reset clears the table and rotor and loads 8 channels, volume 10, enabled.
`default_nettype none

module voice_channel_allocator_core #(
   parameter int MAX_DIST = vca_pkg::MAX_DIST_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [3:0]         csr_data,
   // request items
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_kind,
   input  wire logic [8:0]         req_effect_id,
   input  wire logic [7:0]         req_base_priority,
   input  wire logic signed [4:0]  req_instance_limit,
   input  wire logic [15:0]        req_origin_id,
   input  wire logic [15:0]        req_new_origin_id,
   input  wire logic               req_origin_is_player,
   input  wire logic signed [31:0] req_dx,
   input  wire logic signed [31:0] req_dy,
   input  wire logic [2:0]         req_channel,
   input  wire logic [6:0]         req_volume_request,
   // result items
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_accepted,
   output logic [2:0]              rsp_channel_index,
   output logic [7:0]              rsp_stopped_mask,
   output logic [10:0]             rsp_distance,
   output logic [11:0]             rsp_priority_res
);

   // The sequencer walks a start item through its phases: distance (abs, sum),
   // priority scaling, then up to three passes over the channel table, one
   // channel per cycle: instance limit, origin plus first-free, and the
   // rotating steal pass. The datapath owns the table and item state and reports status.
   vca_pkg::cmd_type cmd;
   vca_pkg::sts_type sts;

   vca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   vca_dpath #(
      .MAX_DIST (MAX_DIST)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_kind             (req_kind),
      .req_effect_id        (req_effect_id),
      .req_base_priority    (req_base_priority),
      .req_instance_limit   (req_instance_limit),
      .req_origin_id        (req_origin_id),
      .req_new_origin_id    (req_new_origin_id),
      .req_origin_is_player (req_origin_is_player),
      .req_dx               (req_dx),
      .req_dy               (req_dy),
      .req_channel          (req_channel),
      .req_volume_request   (req_volume_request),
      .rsp_accepted         (rsp_accepted),
      .rsp_channel_index    (rsp_channel_index),
      .rsp_stopped_mask     (rsp_stopped_mask),
      .rsp_distance         (rsp_distance),
      .rsp_priority_res     (rsp_priority_res)
   );

   // once an item is taken, hold off the next until it is done
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous item still in work");

   // loading the output register always raises valid
   a_load_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("result loaded without valid");

   // a nonzero priority is only reported for a kept voice
   a_prio_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_priority_res != 12'd0 |-> rsp_accepted)
      else $error("priority reported on rejected item");

endmodule

`default_nettype wire

// ===== rtl/core/vca_ctrl.sv =====
// Sequencer of the voice channel allocator: one-hot state machine and handshakes.
// Depends on vca_pkg; drives commands into vca_dpath.
`default_nettype none

module vca_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire vca_pkg::sts_type sts,
   output vca_pkg::cmd_type      cmd
);

   vca_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != vca_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = vca_pkg::OP_IDLE;
      cmd.load_out = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         vca_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op = vca_pkg::OP_LOAD;
               case (sts.req_kind)
                  vca_pkg::KIND_START:
                     state_in = sts.start_ok ? vca_pkg::ST_ABS : vca_pkg::ST_FINISH;
                  vca_pkg::KIND_DONE, vca_pkg::KIND_STOP_ALL: state_in = vca_pkg::ST_SIMPLE;
                  vca_pkg::KIND_STOP:   state_in = vca_pkg::ST_STOP;
                  vca_pkg::KIND_RELINK: state_in = vca_pkg::ST_RELINK;
                  vca_pkg::KIND_UPDATE: state_in = vca_pkg::ST_CHECK;
                  default:              state_in = vca_pkg::ST_FINISH;
               endcase
            end
         end
         vca_pkg::ST_CHECK: begin
            cmd.op   = vca_pkg::OP_CHECK;
            state_in = sts.upd_ok ? vca_pkg::ST_ABS : vca_pkg::ST_FINISH;
         end
         vca_pkg::ST_ABS: begin
            cmd.op   = vca_pkg::OP_ABS;
            state_in = vca_pkg::ST_SUM;
         end
         vca_pkg::ST_SUM: begin
            cmd.op   = vca_pkg::OP_SUM;
            state_in = vca_pkg::ST_PRIO;
         end
         vca_pkg::ST_PRIO: begin
            cmd.op = vca_pkg::OP_PRIO;
            if (sts.is_update) begin
               state_in = sts.far ? vca_pkg::ST_STOP : vca_pkg::ST_FINISH;
            end else if (sts.far) begin
               state_in = vca_pkg::ST_FINISH;
            end else begin
               state_in = sts.limit_skip ? vca_pkg::ST_SCAN : vca_pkg::ST_LIMIT;
            end
         end
         vca_pkg::ST_LIMIT: begin
            cmd.op = vca_pkg::OP_LIMIT;
            if (sts.scan_end) begin
               state_in = sts.lim_fail ? vca_pkg::ST_FINISH : vca_pkg::ST_SCAN;
            end
         end
         vca_pkg::ST_SCAN: begin
            cmd.op = vca_pkg::OP_SCAN;
            if (sts.scan_end) begin
               state_in = sts.pick_hit ? vca_pkg::ST_COMMIT : vca_pkg::ST_STEAL;
            end
         end
         vca_pkg::ST_STOP: begin
            cmd.op = vca_pkg::OP_STOP;
            if (sts.scan_end) begin
               state_in = vca_pkg::ST_FINISH;
            end
         end
         vca_pkg::ST_RELINK: begin
            cmd.op = vca_pkg::OP_RELINK;
            if (sts.scan_end) begin
               state_in = vca_pkg::ST_FINISH;
            end
         end
         vca_pkg::ST_STEAL: begin
            cmd.op = vca_pkg::OP_STEAL;
            if (sts.scan_end) begin
               state_in = vca_pkg::ST_FINISH;
            end else if (sts.steal_hit) begin
               state_in = vca_pkg::ST_COMMIT;
            end
         end
         vca_pkg::ST_COMMIT: begin
            cmd.op   = vca_pkg::OP_COMMIT;
            state_in = vca_pkg::ST_FINISH;
         end
         vca_pkg::ST_SIMPLE: begin
            cmd.op   = vca_pkg::OP_SIMPLE;
            state_in = vca_pkg::ST_FINISH;
         end
         vca_pkg::ST_FINISH: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = vca_pkg::ST_IDLE;
            end
         end
         default: state_in = vca_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vca_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/vca_dpath.sv =====
// Datapath of the voice channel allocator: config, channel table, distance,
// priority, scan counters and result registers. Depends on vca_pkg.
`default_nettype none

module vca_dpath #(
   parameter int MAX_DIST = vca_pkg::MAX_DIST_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire vca_pkg::cmd_type    cmd,
   output vca_pkg::sts_type         sts,
   input  wire logic                csr_write_enable,
   input  wire logic [1:0]          csr_index,
   input  wire logic [3:0]          csr_data,
   input  wire logic [2:0]          req_kind,
   input  wire logic [8:0]          req_effect_id,
   input  wire logic [7:0]          req_base_priority,
   input  wire logic signed [4:0]   req_instance_limit,
   input  wire logic [15:0]         req_origin_id,
   input  wire logic [15:0]         req_new_origin_id,
   input  wire logic                req_origin_is_player,
   input  wire logic signed [31:0]  req_dx,
   input  wire logic signed [31:0]  req_dy,
   input  wire logic [2:0]          req_channel,
   input  wire logic [6:0]          req_volume_request,
   output logic                     rsp_accepted,
   output logic [2:0]               rsp_channel_index,
   output logic [7:0]               rsp_stopped_mask,
   output logic [10:0]              rsp_distance,
   output logic [11:0]              rsp_priority_res
);

   localparam int NCH   = vca_pkg::CHANNELS;
   localparam int STEP  = (MAX_DIST / vca_pkg::PRIO_STEPS == 0) ? 1 :
                          MAX_DIST / vca_pkg::PRIO_STEPS;
   localparam int DW    = vca_pkg::DIST_W;

   // config
   logic [3:0] act_ff, act_in, mvol_ff, mvol_in;
   logic       en_ff, en_in;
   // captured item
   logic [2:0]        kind_ff, kind_in, ch_ff, ch_in;
   logic [8:0]        sid_ff, sid_in;
   logic [7:0]        base_ff, base_in;
   logic signed [4:0] limit_ff, limit_in;
   logic [15:0]       key_ff, key_in, norg_ff, norg_in;
   logic              player_ff, player_in;
   logic [31:0]       dx_ff, dx_in, dy_ff, dy_in;
   // arithmetic
   logic [31:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic [DW-1:0] dist_ff, dist_in;
   logic [11:0]   p_ff, p_in;
   // channel table
   logic [NCH-1:0] busy_ff, busy_in;
   logic [15:0]    origin_ff [NCH];
   logic [15:0]    origin_in [NCH];
   logic [8:0]     sound_ff  [NCH];
   logic [8:0]     sound_in  [NCH];
   logic [11:0]    prio_ff   [NCH];
   logic [11:0]    prio_in   [NCH];
   logic [2:0]     rotor_ff, rotor_in;
   // scan state
   logic [vca_pkg::CNT_W-1:0] i_ff, i_in, found_ff, found_in;
   logic [2:0]  c_ff, c_in, lp_ff, lp_in, match_ff, match_in, free_ff, free_in;
   logic [2:0]  pick_ff, pick_in;
   logic        lp_hit_ff, lp_hit_in, match_hit_ff, match_hit_in, free_hit_ff, free_hit_in;
   logic [11:0] bar_ff, bar_in;
   // working result
   logic        w_acc_ff, w_acc_in;
   logic [2:0]  w_idx_ff, w_idx_in;
   logic [7:0]  w_mask_ff, w_mask_in;
   logic [10:0] w_dist_ff, w_dist_in;
   logic [11:0] w_prio_ff, w_prio_in;

   logic [vca_pkg::CNT_W-1:0] n_cnt, c_next;
   logic [2:0]     rd_idx;
   logic           rd_busy, origin_hit, scan_end, ch_in_range, far, lim_over;
   logic [15:0]    rd_origin;
   logic [8:0]     rd_sound;
   logic [11:0]    rd_prio, product;
   logic [NCH-1:0] rd_bit, lp_bit;
   logic [31:0]    lo;
   logic [32:0]    dsum;
   logic [3:0]     q, factor;
   logic [vca_pkg::CNT_W-1:0] rotor_next;

   assign n_cnt = (act_ff > vca_pkg::CNT_W'(NCH)) ? vca_pkg::CNT_W'(NCH) : act_ff;
   assign rd_idx      = (cmd.op == vca_pkg::OP_STEAL) ? c_ff : i_ff[2:0];
   assign rd_busy     = busy_ff[rd_idx];
   assign rd_origin   = origin_ff[rd_idx];
   assign rd_sound    = sound_ff[rd_idx];
   assign rd_prio     = prio_ff[rd_idx];
   assign rd_bit      = NCH'(1) << rd_idx;
   assign lp_bit      = NCH'(1) << lp_ff;
   assign origin_hit  = rd_busy && (rd_origin == key_ff);
   assign scan_end    = (i_ff == n_cnt);
   assign ch_in_range = ({1'b0, ch_ff} < n_cnt);
   assign far         = (dist_ff >= DW'(MAX_DIST));
   assign lim_over    = ($signed({1'b0, found_ff}) >= limit_ff);
   assign c_next      = {1'b0, c_ff} + 4'd1;
   assign rotor_next  = {1'b0, rotor_ff} + 4'd1;

   // octagonal distance
   assign lo   = (ax_ff < ay_ff) ? ax_ff : ay_ff;
   assign dsum = {1'b0, ax_ff} + {1'b0, ay_ff} - {2'b00, lo[31:1]};

   // distance bucket by constant thresholds, then scale the base priority
   always_comb begin
      q = 4'd0;
      for (int k = 1; k <= vca_pkg::PRIO_STEPS; k++) begin
         if (dist_ff >= DW'(k * STEP)) begin
            q = q + 4'd1;
         end
      end
      factor = (q >= 4'(vca_pkg::PRIO_STEPS)) ? 4'd0 : 4'(vca_pkg::PRIO_STEPS) - q;
   end
   assign product = {4'd0, base_ff} * {8'd0, factor};

   assign sts.req_kind   = req_kind;
   assign sts.start_ok   = en_ff && (mvol_ff != 4'd0) && (req_effect_id != 9'd0) &&
                           (req_volume_request != 7'd0);
   assign sts.upd_ok     = en_ff && (mvol_ff != 4'd0) && ch_in_range && rd_busy &&
                           (rd_sound != 9'd0);
   assign sts.is_update  = (kind_ff == vca_pkg::KIND_UPDATE);
   assign sts.far        = far;
   assign sts.limit_skip = (limit_ff == vca_pkg::LIMIT_NONE);
   assign sts.scan_end   = scan_end;
   assign sts.lim_fail   = lim_over && !lp_hit_ff;
   assign sts.pick_hit   = match_hit_ff || free_hit_ff;
   assign sts.steal_hit  = (p_ff >= rd_prio);

   always_comb begin
      act_in = act_ff;  mvol_in = mvol_ff;  en_in = en_ff;
      kind_in = kind_ff;  ch_in = ch_ff;  sid_in = sid_ff;  base_in = base_ff;
      limit_in = limit_ff;  key_in = key_ff;  norg_in = norg_ff;  player_in = player_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  ax_in = ax_ff;  ay_in = ay_ff;
      dist_in = dist_ff;  p_in = p_ff;
      busy_in = busy_ff;  origin_in = origin_ff;  sound_in = sound_ff;  prio_in = prio_ff;
      rotor_in = rotor_ff;  i_in = i_ff;  found_in = found_ff;  c_in = c_ff;
      lp_in = lp_ff;  match_in = match_ff;  free_in = free_ff;  pick_in = pick_ff;
      lp_hit_in = lp_hit_ff;  match_hit_in = match_hit_ff;  free_hit_in = free_hit_ff;
      bar_in = bar_ff;
      w_acc_in = w_acc_ff;  w_idx_in = w_idx_ff;  w_mask_in = w_mask_ff;
      w_dist_in = w_dist_ff;  w_prio_in = w_prio_ff;

      if (csr_write_enable) begin
         case (csr_index)
            vca_pkg::CSR_ACTIVE_CHANNELS: act_in  = csr_data;
            vca_pkg::CSR_MASTER_VOLUME:   mvol_in = csr_data;
            vca_pkg::CSR_SOUND_ENABLED:   en_in   = csr_data[0];
            default: ;
         endcase
      end

      case (cmd.op)
         vca_pkg::OP_LOAD: begin
            kind_in   = req_kind;
            ch_in     = req_channel;
            sid_in    = req_effect_id;
            base_in   = req_base_priority;
            limit_in  = req_instance_limit;
            key_in    = req_origin_id;
            norg_in   = req_new_origin_id;
            player_in = req_origin_is_player;
            dx_in     = req_dx;
            dy_in     = req_dy;
            i_in      = (req_kind == vca_pkg::KIND_UPDATE) ? {1'b0, req_channel} : '0;
            found_in  = '0;
            lp_hit_in = 1'b0;  match_hit_in = 1'b0;  free_hit_in = 1'b0;
            w_acc_in  = 1'b0;
            w_idx_in  = (req_kind == vca_pkg::KIND_DONE || req_kind == vca_pkg::KIND_UPDATE)
                        ? req_channel : 3'd0;
            w_mask_in = '0;  w_dist_in = '0;  w_prio_in = '0;
         end
         vca_pkg::OP_CHECK: begin
            key_in = rd_origin;
         end
         vca_pkg::OP_ABS: begin
            ax_in = dx_ff[31] ? (~dx_ff + 32'd1) : dx_ff;
            ay_in = dy_ff[31] ? (~dy_ff + 32'd1) : dy_ff;
         end
         vca_pkg::OP_SUM: begin
            dist_in = dsum[32:16];
         end
         vca_pkg::OP_PRIO: begin
            w_dist_in = dist_ff[10:0];
            p_in      = product;
            bar_in    = product;
            i_in      = '0;
            if (kind_ff == vca_pkg::KIND_UPDATE && !far) begin
               prio_in[ch_ff] = product;
               w_acc_in       = 1'b1;
               w_prio_in      = product;
            end
         end
         vca_pkg::OP_LIMIT: begin
            if (scan_end) begin
               // steal the weakest instance once the limit is reached
               if (lim_over && lp_hit_ff) begin
                  busy_in[lp_ff] = 1'b0;
                  w_mask_in      = w_mask_ff | lp_bit;
               end
               i_in = '0;
            end else begin
               if (rd_busy && rd_sound == sid_ff) begin
                  found_in = found_ff + 4'd1;
                  if (bar_ff >= rd_prio) begin
                     lp_in     = rd_idx;
                     bar_in    = rd_prio;
                     lp_hit_in = 1'b1;
                  end
               end
               i_in = i_ff + 4'd1;
            end
         end
         vca_pkg::OP_SCAN: begin
            if (scan_end) begin
               pick_in = match_hit_ff ? match_ff : free_ff;
               // advance the rotor before a steal pass
               rotor_in = (rotor_next >= n_cnt) ? 3'd0 : rotor_next[2:0];
               c_in     = (rotor_next >= n_cnt) ? 3'd0 : rotor_next[2:0];
               i_in     = '0;
               if (match_hit_ff || free_hit_ff) begin
                  rotor_in = rotor_ff;
               end
            end else begin
               if (!player_ff && origin_hit) begin
                  busy_in[rd_idx] = 1'b0;
                  w_mask_in       = w_mask_ff | rd_bit;
                  if (!match_hit_ff) begin
                     match_in     = rd_idx;
                     match_hit_in = 1'b1;
                  end
               end
               if (!rd_busy && !free_hit_ff) begin
                  free_in     = rd_idx;
                  free_hit_in = 1'b1;
               end
               i_in = i_ff + 4'd1;
            end
         end
         vca_pkg::OP_STOP: begin
            if (!scan_end) begin
               if (origin_hit) begin
                  busy_in[rd_idx] = 1'b0;
                  w_mask_in       = w_mask_ff | rd_bit;
               end
               i_in = i_ff + 4'd1;
            end
         end
         vca_pkg::OP_RELINK: begin
            if (!scan_end) begin
               if (origin_hit) begin
                  origin_in[rd_idx] = norg_ff;
               end
               i_in = i_ff + 4'd1;
            end
         end
         vca_pkg::OP_STEAL: begin
            if (!scan_end) begin
               if (p_ff >= rd_prio) begin
                  pick_in = rd_idx;
                  if (rd_busy) begin
                     w_mask_in = w_mask_ff | rd_bit;
                  end
               end else begin
                  i_in = i_ff + 4'd1;
                  c_in = (c_next >= n_cnt) ? 3'd0 : c_next[2:0];
               end
            end
         end
         vca_pkg::OP_COMMIT: begin
            busy_in[pick_ff]   = 1'b1;
            origin_in[pick_ff] = key_ff;
            sound_in[pick_ff]  = sid_ff;
            prio_in[pick_ff]   = p_ff;
            w_acc_in           = 1'b1;
            w_idx_in           = pick_ff;
            w_prio_in          = p_ff;
         end
         vca_pkg::OP_SIMPLE: begin
            if (kind_ff == vca_pkg::KIND_DONE) begin
               if (ch_in_range) begin
                  busy_in[ch_ff]  = 1'b0;
                  sound_in[ch_ff] = 9'd0;
               end
            end else begin
               // stop all: report every busy channel, clear the table
               w_mask_in = busy_ff;
               busy_in   = '0;
               for (int k = 0; k < NCH; k++) begin
                  origin_in[k] = '0;
                  sound_in[k]  = '0;
                  prio_in[k]   = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 4'd8;
         mvol_ff  <= 4'd10;
         en_ff    <= 1'b1;
         busy_ff  <= '0;
         rotor_ff <= '0;
         i_ff     <= '0;
         c_ff     <= '0;
         for (int k = 0; k < NCH; k++) begin
            origin_ff[k] <= '0;
            sound_ff[k]  <= '0;
            prio_ff[k]   <= '0;
         end
      end else begin
         act_ff    <= act_in;
         mvol_ff   <= mvol_in;
         en_ff     <= en_in;
         busy_ff   <= busy_in;
         rotor_ff  <= rotor_in;
         i_ff      <= i_in;
         c_ff      <= c_in;
         origin_ff <= origin_in;
         sound_ff  <= sound_in;
         prio_ff   <= prio_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;   ch_ff <= ch_in;   sid_ff <= sid_in;   base_ff <= base_in;
      limit_ff <= limit_in;  key_ff <= key_in; norg_ff <= norg_in; player_ff <= player_in;
      dx_ff    <= dx_in;     dy_ff <= dy_in;   ax_ff <= ax_in;     ay_ff <= ay_in;
      dist_ff  <= dist_in;   p_ff <= p_in;     found_ff <= found_in;
      lp_ff    <= lp_in;     match_ff <= match_in;  free_ff <= free_in;  pick_ff <= pick_in;
      lp_hit_ff <= lp_hit_in;  match_hit_ff <= match_hit_in;  free_hit_ff <= free_hit_in;
      bar_ff   <= bar_in;
      w_acc_ff <= w_acc_in;  w_idx_ff <= w_idx_in;  w_mask_ff <= w_mask_in;
      w_dist_ff <= w_dist_in;  w_prio_ff <= w_prio_in;
      if (cmd.load_out) begin
         rsp_accepted      <= w_acc_ff;
         rsp_channel_index <= w_idx_ff;
         rsp_stopped_mask  <= w_mask_ff;
         rsp_distance      <= w_dist_ff;
         rsp_priority_res  <= w_prio_ff;
      end
   end

endmodule

`default_nettype wire
